// ===== sv/cle_pkg.sv =====
// Shared types and constants for the cursor line editor.
// Holds key codes, the controller state type and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package cle_pkg;

   // Editing keys
   localparam logic [7:0] KEY_LEFT  = 8'h3C;
   localparam logic [7:0] KEY_RIGHT = 8'h3E;
   localparam logic [7:0] KEY_BACK  = 8'h2D;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOVE_L,
      ST_MOVE_R,
      ST_FLUSH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;        // capture the incoming beat
      logic move_l_rd;   // pop before stack (read top)
      logic move_l_wr;   // push popped char onto after stack
      logic move_r_rd;   // pop after stack (read top)
      logic move_r_wr;   // push popped char onto before stack
      logic back;        // drop char before cursor
      logic insert;      // insert key at cursor, or mark overflow
      logic flush_read;  // read next char of the line for output
      logic emit_empty;  // emit the empty-line marker
      logic clear;       // reset counts, overflow mark and flush index
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_left;
      logic is_right;
      logic is_back;
      logic can_left;
      logic can_right;
      logic can_back;
      logic eol;
      logic line_empty;
      logic flush_done;
   } status_type;

endpackage

// ===== sv/cursor_line_editor_top.sv =====
// A plain key passes through EXEC back to idle; a cursor move also passes through a
// MOVE state, since the registered store read puts the push in the cycle after the pop.
// End of line: after EXEC (and a MOVE state with a move) the FLUSH state reads the
// line out, one beat per cycle for n characters (one beat for an empty line); busy holds
// through the flush, and a new key is accepted only once busy drops back in idle.
// Reset (synchronous, active high) empties the line. The receiver cannot stall.
`timescale 1ns / 1ps

module cursor_line_editor_top
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_key,
   input  logic       req_end_of_line,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last,
   output logic       rsp_empty_line,
   output logic       rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   cle_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   cle_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_key         (req_key),
      .req_end_of_line (req_end_of_line),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_last        (rsp_last),
      .rsp_empty_line  (rsp_empty_line),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

// ===== sv/cle_ctrl.sv =====
// Controller state machine of the cursor line editor.
// Depends on cle_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps

module cle_ctrl
   import cle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;
   logic      key_moves;

   assign key_moves = (status.is_left && status.can_left) ||
                      (status.is_right && status.can_right);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            priority if (status.is_left && status.can_left) state_in = ST_MOVE_L;
            else if (status.is_right && status.can_right) state_in = ST_MOVE_R;
            else if (status.eol) state_in = ST_FLUSH;
            else state_in = ST_IDLE;
         end
         ST_MOVE_L, ST_MOVE_R: begin
            state_in = status.eol ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (status.line_empty || status.flush_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: begin
            cmd.move_l_rd = status.is_left && status.can_left;
            cmd.move_r_rd = status.is_right && status.can_right && !key_moves
                            ? 1'b0 : status.is_right && status.can_right;
            cmd.back      = status.is_back && status.can_back;
            cmd.insert    = !status.is_left && !status.is_right && !status.is_back;
         end
         ST_MOVE_L: begin
            cmd.move_l_wr = 1'b1;
         end
         ST_MOVE_R: begin
            cmd.move_r_wr = 1'b1;
         end
         ST_FLUSH: begin
            priority if (status.line_empty) begin
               cmd.emit_empty = 1'b1;
               cmd.clear      = 1'b1;
            end else if (!status.flush_done) begin
               cmd.flush_read = 1'b1;
            end else begin
               cmd.clear = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/cle_datapath.sv =====
// Datapath of the cursor line editor: the two character stacks, their
// counts, the overflow mark and the output run registers.
// Depends on cle_pkg for key codes and the command/status bundles.
`timescale 1ns / 1ps

module cle_datapath
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] req_key,
   input  logic       req_end_of_line,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last,
   output logic       rsp_empty_line,
   output logic       rsp_overflow
);

   localparam int AW = $clog2(LINE_CAPACITY);
   localparam int CW = $clog2(LINE_CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(LINE_CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // Stack stores and their registered read data
   logic [7:0] before_mem_ff [LINE_CAPACITY];
   logic [7:0] after_mem_ff  [LINE_CAPACITY];
   logic [7:0] before_rd_ff;
   logic [7:0] after_rd_ff;

   // Captured beat
   logic [7:0] key_ff;
   logic       eol_ff;

   // Control registers
   logic [CW-1:0] bc_ff, bc_in;
   logic [CW-1:0] ac_ff, ac_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          dropped_ff, dropped_in;

   // Output run registers
   logic pend_valid_ff;
   logic pend_sel_ff;
   logic pend_empty_ff;
   logic pend_last_ff;
   logic pend_ovf_ff;

   logic [CW-1:0] total;
   logic [CW-1:0] bc_dec;
   logic [CW-1:0] ac_dec;
   logic [CW-1:0] after_flush;
   logic          room;
   logic          from_after;

   logic          before_we, after_we, before_re, after_re;
   logic [AW-1:0] before_waddr, after_waddr, before_raddr, after_raddr;
   logic [7:0]    before_wdata;

   // The two counts never sum past the capacity
   assign total       = bc_ff + ac_ff;
   assign bc_dec      = bc_ff - ONE_C;
   assign ac_dec      = ac_ff - ONE_C;
   assign after_flush = total - idx_ff - ONE_C;
   assign room        = total < CAP_C;
   assign from_after  = idx_ff >= bc_ff;

   // Status toward the controller
   always_comb begin
      status.is_left    = key_ff == KEY_LEFT;
      status.is_right   = key_ff == KEY_RIGHT;
      status.is_back    = key_ff == KEY_BACK;
      status.can_left   = (bc_ff != '0) && (ac_ff < CAP_C);
      status.can_right  = (ac_ff != '0) && (bc_ff < CAP_C);
      status.can_back   = bc_ff != '0;
      status.eol        = eol_ff;
      status.line_empty = total == '0;
      status.flush_done = idx_ff == total;
   end

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_key;
         eol_ff <= req_end_of_line;
      end
   end

   // Store port control
   assign before_we    = (cmd.insert && room) || cmd.move_r_wr;
   assign before_waddr = bc_ff[AW-1:0];
   assign before_wdata = cmd.insert ? key_ff : after_rd_ff;
   assign after_we     = cmd.move_l_wr;
   assign after_waddr  = ac_ff[AW-1:0];
   assign before_re    = cmd.move_l_rd || (cmd.flush_read && !from_after);
   assign before_raddr = cmd.flush_read ? idx_ff[AW-1:0] : bc_dec[AW-1:0];
   assign after_re     = cmd.move_r_rd || (cmd.flush_read && from_after);
   assign after_raddr  = cmd.flush_read ? after_flush[AW-1:0] : ac_dec[AW-1:0];

   // Before-cursor stack
   always_ff @(posedge clock) begin
      if (before_we) before_mem_ff[before_waddr] <= before_wdata;
      if (before_re) before_rd_ff <= before_mem_ff[before_raddr];
   end

   // After-cursor stack
   always_ff @(posedge clock) begin
      if (after_we) after_mem_ff[after_waddr] <= before_rd_ff;
      if (after_re) after_rd_ff <= after_mem_ff[after_raddr];
   end

   // Advance counts, flush index and overflow mark
   always_comb begin
      bc_in      = bc_ff;
      ac_in      = ac_ff;
      idx_in     = idx_ff;
      dropped_in = dropped_ff;
      priority if (cmd.clear) begin
         bc_in      = '0;
         ac_in      = '0;
         idx_in     = '0;
         dropped_in = 1'b0;
      end else begin
         if (cmd.move_l_rd || cmd.back) bc_in = bc_dec;
         if ((cmd.insert && room) || cmd.move_r_wr) bc_in = bc_ff + ONE_C;
         if (cmd.insert && !room) dropped_in = 1'b1;
         if (cmd.move_r_rd) ac_in = ac_dec;
         if (cmd.move_l_wr) ac_in = ac_ff + ONE_C;
         if (cmd.flush_read) idx_in = idx_ff + ONE_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff      <= '0;
         ac_ff      <= '0;
         idx_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         bc_ff      <= bc_in;
         ac_ff      <= ac_in;
         idx_ff     <= idx_in;
         dropped_ff <= dropped_in;
      end
   end

   // Output run: each beat comes out in the cycle after its store read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.flush_read || cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      pend_sel_ff   <= from_after;
      pend_empty_ff <= cmd.emit_empty;
      pend_last_ff  <= cmd.emit_empty || (idx_ff == (total - ONE_C));
      pend_ovf_ff   <= dropped_ff;
   end

   assign rsp_strobe     = pend_valid_ff;
   assign rsp_out_char   = pend_empty_ff ? 8'h00 : (pend_sel_ff ? after_rd_ff : before_rd_ff);
   assign rsp_last       = pend_last_ff;
   assign rsp_empty_line = pend_empty_ff;
   assign rsp_overflow   = pend_ovf_ff;

endmodule

// ===== sv/cle_checker.sv =====
// Port-level checks for the cursor line editor, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cle_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last,
   input logic       rsp_empty_line,
   input logic       rsp_overflow
);

   // An empty-line beat is a lone, zero-valued final beat
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_empty_line |-> rsp_last && (rsp_out_char == 8'h00))
      else $error("empty-line beat not final or nonzero");

   // An accepted beat raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after accepted beat");

   // A line's output run has no gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside output run");

   // A final beat is followed by a quiet cycle
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result beat right after final beat");

   // A result beat carries only known bits
   a_beat_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown({rsp_out_char, rsp_last, rsp_empty_line, rsp_overflow}))
      else $error("unknown bits on result beat");

endmodule

bind cursor_line_editor_top cle_checker u_cle_checker (.*);

// ===== dv/cle_line_checker.sv =====
// Line checker for the cursor line editor: predicts each emitted line and compares.
// Watches the key channel and the result channel of cursor_line_editor_top.
// Depends on cle_pkg for the editing key codes.
`timescale 1ns / 1ps

module cle_line_checker
   import cle_pkg::*;
#(
   parameter int LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [7:0] req_key,
   input  logic       req_end_of_line,
   input  logic       rsp_strobe,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_last,
   input  logic       rsp_empty_line,
   input  logic       rsp_overflow,
   output int         error_count,
   output int         pending
);

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       empty_line;
      logic       overflow;
   } line_beat_type;

   // Expected result beats, oldest first
   line_beat_type line_beats_due[$];

   // Shadow of the editor: text left of the cursor and text right of it
   logic [7:0] left_text [LINE_CAPACITY];
   logic [7:0] right_text [LINE_CAPACITY];
   int         left_len;
   int         right_len;
   logic       lost_insert;
   int         errs;

   initial begin
      error_count = 0;
      pending     = 0;
      errs        = 0;
      left_len    = 0;
      right_len   = 0;
      lost_insert = 1'b0;
   end

   // Apply one keystroke to the shadow line
   function automatic void edit_line(logic [7:0] key);
      if (key == KEY_LEFT) begin
         if (left_len > 0 && right_len < LINE_CAPACITY) begin
            left_len--;
            right_text[right_len] = left_text[left_len];
            right_len++;
         end
      end else if (key == KEY_RIGHT) begin
         if (right_len > 0 && left_len < LINE_CAPACITY) begin
            right_len--;
            left_text[left_len] = right_text[right_len];
            left_len++;
         end
      end else if (key == KEY_BACK) begin
         if (left_len > 0)
            left_len--;
      end else begin
         if (left_len + right_len < LINE_CAPACITY) begin
            left_text[left_len] = key;
            left_len++;
         end else begin
            lost_insert = 1'b1;
         end
      end
   endfunction

   // Queue the whole line in text order, then clear the shadow
   function automatic void flush_line();
      int            total;
      int            n;
      line_beat_type beat;
      total = left_len + right_len;
      n     = 0;
      if (total == 0) begin
         beat.out_char   = 8'h00;
         beat.last       = 1'b1;
         beat.empty_line = 1'b1;
         beat.overflow   = lost_insert;
         line_beats_due.push_back(beat);
      end else begin
         for (int i = 0; i < left_len; i++) begin
            beat.out_char   = left_text[i];
            beat.last       = (n + 1 == total);
            beat.empty_line = 1'b0;
            beat.overflow   = lost_insert;
            line_beats_due.push_back(beat);
            n++;
         end
         for (int i = right_len; i > 0; i--) begin
            beat.out_char   = right_text[i - 1];
            beat.last       = (n + 1 == total);
            beat.empty_line = 1'b0;
            beat.overflow   = lost_insert;
            line_beats_due.push_back(beat);
            n++;
         end
      end
      left_len    = 0;
      right_len   = 0;
      lost_insert = 1'b0;
   endfunction

   // Compare one result beat against the oldest expectation
   function automatic void check_beat();
      line_beat_type want;
      if (line_beats_due.size() == 0) begin
         $error("result beat with nothing outstanding: out_char %02h last %0b",
                rsp_out_char, rsp_last);
         errs++;
      end else begin
         want = line_beats_due.pop_front();
         if (rsp_out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, rsp_out_char);
            errs++;
         end
         if (rsp_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp_last);
            errs++;
         end
         if (rsp_empty_line !== want.empty_line) begin
            $error("empty_line: expected %0b, got %0b", want.empty_line, rsp_empty_line);
            errs++;
         end
         if (rsp_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
            errs++;
         end
      end
   endfunction

   // Check results first, then take in any key beat accepted at this edge
   always @(posedge clock) begin
      if (reset) begin
         left_len    = 0;
         right_len   = 0;
         lost_insert = 1'b0;
      end else begin
         if (rsp_strobe === 1'b1)
            check_beat();
         if (start && busy === 1'b0) begin
            edit_line(req_key);
            if (req_end_of_line)
               flush_line();
         end
      end
      pending     <= line_beats_due.size();
      error_count <= errs;
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for cursor_line_editor_top: clock, reset, keystroke stimulus, verdict.
// Depends on cle_pkg, cursor_line_editor_top and cle_line_checker.
`timescale 1ns / 1ps

module tb
   import cle_pkg::*;
();

   localparam int CAP        = 64;
   localparam int KEY_TARGET = 230;

   typedef enum int {
      LINE_SHORT,
      LINE_FILL,
      LINE_SCRUB
   } line_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_key = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_strobe;
   logic [7:0] rsp_out_char;
   logic       rsp_last;
   logic       rsp_empty_line;
   logic       rsp_overflow;
   int         error_count;
   int         pending;
   int         keys_sent = 0;
   bit         idle_on = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cursor_line_editor_top #(.LINE_CAPACITY(CAP)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .req_end_of_line (req_end_of_line),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_last        (rsp_last),
      .rsp_empty_line  (rsp_empty_line),
      .rsp_overflow    (rsp_overflow)
   );

   cle_line_checker #(.LINE_CAPACITY(CAP)) line_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .req_end_of_line (req_end_of_line),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_char    (rsp_out_char),
      .rsp_last        (rsp_last),
      .rsp_empty_line  (rsp_empty_line),
      .rsp_overflow    (rsp_overflow),
      .error_count     (error_count),
      .pending         (pending)
   );

   // Hold one key beat until the editor takes it
   task automatic send_key(input logic [7:0] key, input logic eol);
      start           <= 1'b1;
      req_key         <= key;
      req_end_of_line <= eol;
      @(posedge clock);
      while (busy) @(posedge clock);
      keys_sent++;
   endtask

   // Drop start for a few cycles, with junk on the data ports
   task automatic idle(input int cycles);
      start           <= 1'b0;
      req_key         <= 8'($urandom);
      req_end_of_line <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (idle_on && $urandom_range(0, 3) == 0)
         idle($urandom_range(1, 15));
   endtask

   // Stop sending until every predicted beat has come out
   task automatic drain(input int tail);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Each edit key shows up about once in spread+1 draws; the rest are any byte
   function automatic logic [7:0] pick_key(input int spread);
      case ($urandom_range(0, spread))
         0:       return KEY_LEFT;
         1:       return KEY_RIGHT;
         2:       return KEY_BACK;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == KEY_LEFT || c == KEY_RIGHT || c == KEY_BACK)
         c = c ^ 8'h40;
      return c;
   endfunction

   // One line of edits, closed by an end-of-line beat
   task automatic run_line(input line_kind_type kind);
      int len;
      case (kind)
         LINE_SHORT: begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               maybe_pause();
               send_key(pick_key(9), i == len - 1);
            end
         end
         LINE_FILL: begin
            len = CAP + $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               maybe_pause();
               send_key(pick_key(29), i == len - 1);
            end
         end
         LINE_SCRUB: begin
            // overfill, then delete everything: empty line that still shows overflow
            for (int i = 0; i < CAP + 2; i++) begin
               maybe_pause();
               send_key(pick_char(), 1'b0);
            end
            for (int i = 0; i < CAP; i++) begin
               maybe_pause();
               send_key(KEY_BACK, i == CAP - 1);
            end
         end
         default: ;
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: cursor at both ends, byte extremes, empty lines
      send_key(KEY_LEFT, 1'b1);
      send_key(KEY_BACK, 1'b0);
      send_key(KEY_RIGHT, 1'b0);
      send_key(8'h00, 1'b0);
      send_key(8'hFF, 1'b0);
      send_key(KEY_RIGHT, 1'b0);
      send_key(KEY_LEFT, 1'b0);
      send_key(KEY_LEFT, 1'b0);
      send_key(KEY_LEFT, 1'b0);
      send_key(KEY_BACK, 1'b0);
      send_key(8'h55, 1'b0);
      send_key(KEY_RIGHT, 1'b0);
      send_key(KEY_BACK, 1'b0);
      send_key(8'hAA, 1'b1);
      send_key(8'h41, 1'b0);
      send_key(KEY_BACK, 1'b1);
      send_key(8'h7F, 1'b1);
      send_key(KEY_BACK, 1'b1);
      send_key(KEY_RIGHT, 1'b1);
      drain(8);

      // Random lines; no idling in the last stretch
      idle_on = 1'b1;
      run_line(LINE_SCRUB);
      while (keys_sent < KEY_TARGET) begin
         idle_on = (keys_sent < KEY_TARGET - 40) && ($urandom_range(0, 2) != 0);
         // keep a full line from running far past the key budget
         if (keys_sent + CAP + 6 <= KEY_TARGET && $urandom_range(0, 5) == 0)
            run_line(LINE_FILL);
         else
            run_line(LINE_SHORT);
         if (idle_on && $urandom_range(0, 7) == 0)
            drain(4);
      end

      drain(16);
      if (error_count == 0)
         $display("PASS cursor_line_editor_top");
      else
         $display("FAIL cursor_line_editor_top");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL cursor_line_editor_top");
      $finish;
   end

endmodule

// ===== cursor_line_editor_top.f =====
sv/cle_pkg.sv
sv/cle_ctrl.sv
sv/cle_datapath.sv
sv/cursor_line_editor_top.sv
sv/cle_checker.sv
dv/cle_line_checker.sv
dv/tb.sv
